// ----- rtl/count_ranked_tally_table_defines.svh -----
// ----------------------------------------------------------------------------
// count_ranked_tally_table_defines
// Assertion macros used by the checker of the tally table.
// ----------------------------------------------------------------------------
`ifndef COUNT_RANKED_TALLY_TABLE_DEFINES_SVH
`define COUNT_RANKED_TALLY_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while reset is asserted.
`define CRTT_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while reset is asserted.
`define CRTT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/crtt_pkg.sv -----
// ----------------------------------------------------------------------------
// crtt_pkg
// Sizes, codes and the table entry type of the ranked tally table.
// ----------------------------------------------------------------------------
package crtt_pkg;

  // Table geometry: every choice plus one catch-all invalid entry.
  localparam int MAX_CHOICES = 16;
  localparam int TABLE_DEPTH = MAX_CHOICES + 1;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int USED_W      = $clog2(TABLE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int CNT_W       = 32;

  // Request operation codes.
  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_CLOSE = 2'd1,
    OP_VOTE  = 2'd2,
    OP_READ  = 2'd3
  } opcode_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EARLY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  // One table entry as held in the memory.
  typedef struct packed {
    logic             inv;
    logic [ID_W-1:0]  id;
    logic [CNT_W-1:0] cnt;
  } entry_t;

endpackage

// ----- rtl/count_ranked_tally_table.sv -----
// ----------------------------------------------------------------------------
// count_ranked_tally_table
// Vote tally table kept in descending count order in a memory with one write and one read port.
// ----------------------------------------------------------------------------
// Requests are handled one at a time; a new request is taken as soon as the
// sequencer is back in idle, even while the previous result still waits in
// the output register. Every request passes through idle and the finish
// step. Add and close go straight from idle to finish, and so does any
// refused request (table full or closed, vote before close, rank out of
// range). An accepted read passes through a read-wait step for the table
// memory. A vote scans the entries (up to entries_used), one read of the
// table memory for each, then bubbles the entry up one rank per read while
// its count exceeds the one above and writes it at its final rank. A vote to
// a saturated count skips the bubble and place steps. The finish step waits
// while an earlier result is still held in the output register.
module count_ranked_tally_table
  import crtt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_choice_id,
  input  logic [4:0]  in_rank,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_rank_id,
  output logic        out_rank_is_invalid,
  output logic [31:0] out_rank_votes,
  output logic [31:0] out_total_votes,
  output logic [31:0] out_valid_votes,
  output logic [31:0] out_white_votes,
  output logic [31:0] out_invalid_votes,
  output logic [4:0]  out_entries_used
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_RDWAIT = 6'b000010,
    S_SCAN   = 6'b000100,
    S_BUBBLE = 6'b001000,
    S_PLACE  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  // Saturating increment of a count.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == '1) ? v : v + CNT_W'(1);
  endfunction

  // Control state.
  state_t            state_r, state_nxt;
  logic [USED_W-1:0] used_r, used_nxt;
  logic              closed_r, closed_nxt;
  logic [CNT_W-1:0]  sum_all_r, sum_all_nxt;
  logic [CNT_W-1:0]  sum_valid_r, sum_valid_nxt;
  logic [CNT_W-1:0]  sum_white_r, sum_white_nxt;
  logic [CNT_W-1:0]  sum_inv_r, sum_inv_nxt;
  logic              out_valid_r, out_valid_nxt;

  // Working registers of the sequencer.
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [IDX_W-1:0]  inv_idx_r, inv_idx_nxt;
  logic [CNT_W-1:0]  inv_cnt_r, inv_cnt_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  entry_t            cur_r, cur_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [ID_W-1:0]   res_id_r, res_id_nxt;
  logic              res_inv_r, res_inv_nxt;
  logic [CNT_W-1:0]  res_votes_r, res_votes_nxt;

  // Output register.
  logic              out_load;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_id_r;
  logic              out_inv_r;
  logic [CNT_W-1:0]  out_votes_r;
  logic [CNT_W-1:0]  out_all_r;
  logic [CNT_W-1:0]  out_valid_sum_r;
  logic [CNT_W-1:0]  out_white_r;
  logic [CNT_W-1:0]  out_inv_sum_r;
  logic [USED_W-1:0] out_used_r;

  // Table memory ports.
  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_data_r;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  entry_t            mem_wdata;
  logic              mem_re;
  logic [IDX_W-1:0]  mem_raddr;

  // Scan helpers.
  logic              scan_match;
  logic              scan_last;
  logic              found;
  logic [IDX_W-1:0]  found_idx;
  entry_t            found_ent;

  assign in_ready = (state_r == S_IDLE);

  // Table memory, one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  // Scan step: a matching valid entry ends the search; at the end of the
  // table the vote falls back to the invalid entry.
  always_comb begin
    scan_match = !rd_data_r.inv && (rd_data_r.id == id_r);
    scan_last  = (USED_W'(scan_r) + USED_W'(1)) >= used_r;
    found      = 1'b0;
    found_idx  = scan_r;
    found_ent  = rd_data_r;
    if (scan_match) begin
      found = 1'b1;
    end else if (scan_last) begin
      found = 1'b1;
      if (!rd_data_r.inv) begin
        found_idx = inv_idx_r;
        found_ent = '{inv: 1'b1, id: '0, cnt: inv_cnt_r};
      end
    end
  end

  // Sequencer.
  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    closed_nxt     = closed_r;
    sum_all_nxt    = sum_all_r;
    sum_valid_nxt  = sum_valid_r;
    sum_white_nxt  = sum_white_r;
    sum_inv_nxt    = sum_inv_r;
    id_nxt         = id_r;
    scan_nxt       = scan_r;
    inv_idx_nxt    = inv_idx_r;
    inv_cnt_nxt    = inv_cnt_r;
    pos_nxt        = pos_r;
    cur_nxt        = cur_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    res_inv_nxt    = res_inv_r;
    res_votes_nxt  = res_votes_r;
    mem_we         = 1'b0;
    mem_waddr      = pos_r;
    mem_wdata      = cur_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;
    out_load       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          res_status_nxt = ST_OK;
          res_id_nxt     = '0;
          res_inv_nxt    = 1'b0;
          res_votes_nxt  = '0;
          id_nxt         = in_choice_id;
          state_nxt      = S_FINISH;
          unique case (opcode_t'(in_opcode))
            OP_ADD: begin
              if (closed_r || used_r >= USED_W'(MAX_CHOICES)) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(used_r);
                mem_wdata = '{inv: 1'b0, id: in_choice_id, cnt: '0};
                used_nxt  = used_r + USED_W'(1);
              end
            end
            OP_CLOSE: begin
              if (closed_r || used_r >= USED_W'(TABLE_DEPTH)) begin
                res_status_nxt = ST_FULL;
              end else begin
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(used_r);
                mem_wdata  = '{inv: 1'b1, id: '0, cnt: '0};
                used_nxt   = used_r + USED_W'(1);
                closed_nxt = 1'b1;
              end
            end
            OP_VOTE: begin
              if (!closed_r) begin
                res_status_nxt = ST_EARLY;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                scan_nxt  = '0;
                state_nxt = S_SCAN;
              end
            end
            OP_READ: begin
              if (USED_W'(in_rank) >= used_r) begin
                res_status_nxt = ST_RANGE;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = IDX_W'(in_rank);
                state_nxt = S_RDWAIT;
              end
            end
          endcase
        end
      end

      // Read data of the requested rank is back.
      S_RDWAIT: begin
        res_inv_nxt   = rd_data_r.inv;
        res_id_nxt    = rd_data_r.inv ? '0 : rd_data_r.id;
        res_votes_nxt = rd_data_r.cnt;
        state_nxt     = S_FINISH;
      end

      // Walk the table for the voted id, noting the invalid entry on the way.
      S_SCAN: begin
        if (found) begin
          if (found_ent.cnt == '1) begin
            state_nxt = S_FINISH;
          end else begin
            cur_nxt     = found_ent;
            cur_nxt.cnt = found_ent.cnt + CNT_W'(1);
            pos_nxt     = found_idx;
            sum_all_nxt = sat_inc(sum_all_r);
            if (found_ent.inv) begin
              sum_inv_nxt = sat_inc(sum_inv_r);
            end else begin
              sum_valid_nxt = sat_inc(sum_valid_r);
              if (found_ent.id == '0) begin
                sum_white_nxt = sat_inc(sum_white_r);
              end
            end
            if (found_idx == '0) begin
              state_nxt = S_PLACE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = found_idx - IDX_W'(1);
              state_nxt = S_BUBBLE;
            end
          end
        end else begin
          if (rd_data_r.inv) begin
            inv_idx_nxt = scan_r;
            inv_cnt_nxt = rd_data_r.cnt;
          end
          scan_nxt  = scan_r + IDX_W'(1);
          mem_re    = 1'b1;
          mem_raddr = scan_r + IDX_W'(1);
        end
      end

      // The predecessor moves down one rank while the voted count exceeds it.
      S_BUBBLE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (cur_r.cnt > rd_data_r.cnt) begin
          mem_wdata = rd_data_r;
          pos_nxt   = pos_r - IDX_W'(1);
          if (pos_r == IDX_W'(1)) begin
            state_nxt = S_PLACE;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_r - IDX_W'(2);
          end
        end else begin
          mem_wdata = cur_r;
          state_nxt = S_FINISH;
        end
      end

      // Write the voted entry at its final rank.
      S_PLACE: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = cur_r;
        state_nxt = S_FINISH;
      end

      // Hand the result over once the output register is free.
      S_FINISH: begin
        if (!out_valid_r || out_ready) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      used_r      <= '0;
      closed_r    <= 1'b0;
      sum_all_r   <= '0;
      sum_valid_r <= '0;
      sum_white_r <= '0;
      sum_inv_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      used_r      <= used_nxt;
      closed_r    <= closed_nxt;
      sum_all_r   <= sum_all_nxt;
      sum_valid_r <= sum_valid_nxt;
      sum_white_r <= sum_white_nxt;
      sum_inv_r   <= sum_inv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    id_r         <= id_nxt;
    scan_r       <= scan_nxt;
    inv_idx_r    <= inv_idx_nxt;
    inv_cnt_r    <= inv_cnt_nxt;
    pos_r        <= pos_nxt;
    cur_r        <= cur_nxt;
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    res_inv_r    <= res_inv_nxt;
    res_votes_r  <= res_votes_nxt;
    if (out_load) begin
      out_status_r    <= res_status_r;
      out_id_r        <= res_id_r;
      out_inv_r       <= res_inv_r;
      out_votes_r     <= res_votes_r;
      out_all_r       <= sum_all_r;
      out_valid_sum_r <= sum_valid_r;
      out_white_r     <= sum_white_r;
      out_inv_sum_r   <= sum_inv_r;
      out_used_r      <= used_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_rank_id         = out_id_r;
  assign out_rank_is_invalid = out_inv_r;
  assign out_rank_votes      = out_votes_r;
  assign out_total_votes     = out_all_r;
  assign out_valid_votes     = out_valid_sum_r;
  assign out_white_votes     = out_white_r;
  assign out_invalid_votes   = out_inv_sum_r;
  assign out_entries_used    = 5'(out_used_r);

endmodule

// ----- rtl/crtt_checker.sv -----
// ----------------------------------------------------------------------------
// crtt_checker
// Port-level checks of the ranked tally table, bound to its top level.
// ----------------------------------------------------------------------------
`include "count_ranked_tally_table_defines.svh"

module crtt_checker
  import crtt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [15:0] out_rank_id,
  input logic        out_rank_is_invalid,
  input logic [31:0] out_rank_votes,
  input logic [31:0] out_total_votes,
  input logic [31:0] out_valid_votes,
  input logic [31:0] out_white_votes,
  input logic [31:0] out_invalid_votes,
  input logic [4:0]  out_entries_used
);

  // A stalled result stays valid and keeps its total vote count.
  `CRTT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_total_votes), "stalled result changed")

  // Unsaturated total is the sum of valid and invalid votes.
  `CRTT_ASSERT_HOLDS(a_total_split, out_valid && (out_total_votes != 32'hFFFF_FFFF), out_total_votes == out_valid_votes + out_invalid_votes, "total does not match valid plus invalid")

  // White votes are a part of the valid votes.
  `CRTT_ASSERT_HOLDS(a_white_le_valid, out_valid, out_white_votes <= out_valid_votes, "white votes exceed valid votes")

  // A failed request reports no entry.
  `CRTT_ASSERT_HOLDS(a_fail_no_entry, out_valid && (out_status != ST_OK), (out_rank_votes == '0) && (out_rank_id == '0) && !out_rank_is_invalid, "failed request carries entry data")

  // The table never holds more entries than it has rows.
  `CRTT_ASSERT_HOLDS(a_used_bound, out_valid, out_entries_used <= 5'(TABLE_DEPTH), "entry count beyond table depth")

endmodule

bind count_ranked_tally_table crtt_checker u_crtt_checker (.*);

// ----- tb/tb_count_ranked_tally_table.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_count_ranked_tally_table
// Self-checking bench for the ranked tally table. A ledger class keeps its
// own copy of the table and the running totals. It predicts one result for
// every request the block takes and compares each returned result, field by
// field, in order. Requests start with a short directed list: an empty
// table, a full table, double close, early vote and out-of-range reads.
// Random votes and reads follow, under three patterns of sender and
// receiver idling.
// ----------------------------------------------------------------------------
package tally_check_pkg;
  import crtt_pkg::*;

  // One result as the block should present it.
  typedef struct {
    status_t          status;
    logic [ID_W-1:0]  rank_id;
    logic             rank_is_invalid;
    logic [CNT_W-1:0] rank_votes;
    logic [CNT_W-1:0] total_votes;
    logic [CNT_W-1:0] valid_votes;
    logic [CNT_W-1:0] white_votes;
    logic [CNT_W-1:0] invalid_votes;
    logic [4:0]       entries_used;
  } tally_t;

  // Ledger of the ballot: predicts each result and checks the returned ones.
  // A count cannot come near saturation in a run this short. The predictor
  // still stops counts and totals at the top value.
  class tally_ledger;
    localparam int PRINT_LIMIT = 100;

    bit [ID_W-1:0]  slot_ids[TABLE_DEPTH];
    bit             slot_inv[TABLE_DEPTH];
    bit [CNT_W-1:0] slot_cnt[TABLE_DEPTH];
    int             used;
    bit             closed;
    bit [CNT_W-1:0] all_sum;
    bit [CNT_W-1:0] valid_sum;
    bit [CNT_W-1:0] white_sum;
    bit [CNT_W-1:0] invalid_sum;
    tally_t         expected_tallies[$];
    int             errors;
    int             results_seen;

    function bit [CNT_W-1:0] sat_add1(bit [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
    endfunction

    function int pending();
      return expected_tallies.size();
    endfunction

    // Count one vote and let the entry climb past lower counts.
    function void tally_vote(bit [ID_W-1:0] id);
      int             hit;
      bit [ID_W-1:0]  t_id;
      bit             t_inv;
      bit [CNT_W-1:0] t_cnt;
      hit = -1;
      for (int i = 0; i < used; i++) begin
        if (hit < 0 && !slot_inv[i] && slot_ids[i] == id) hit = i;
      end
      // No matching choice: the vote falls to the invalid entry.
      for (int i = 0; i < used; i++) begin
        if (hit < 0 && slot_inv[i]) hit = i;
      end
      if (hit < 0 || slot_cnt[hit] == '1) return;
      slot_cnt[hit] = slot_cnt[hit] + CNT_W'(1);
      all_sum = sat_add1(all_sum);
      if (slot_inv[hit]) begin
        invalid_sum = sat_add1(invalid_sum);
      end else begin
        valid_sum = sat_add1(valid_sum);
        if (slot_ids[hit] == '0) white_sum = sat_add1(white_sum);
      end
      // Ties keep their order, so only a strictly higher count moves up.
      while (hit > 0 && slot_cnt[hit] > slot_cnt[hit-1]) begin
        t_id  = slot_ids[hit];
        t_inv = slot_inv[hit];
        t_cnt = slot_cnt[hit];
        slot_ids[hit]   = slot_ids[hit-1];
        slot_inv[hit]   = slot_inv[hit-1];
        slot_cnt[hit]   = slot_cnt[hit-1];
        slot_ids[hit-1] = t_id;
        slot_inv[hit-1] = t_inv;
        slot_cnt[hit-1] = t_cnt;
        hit--;
      end
    endfunction

    // Apply one accepted request and queue the result it must produce.
    function void note_request(opcode_t op, bit [ID_W-1:0] id, bit [4:0] rank);
      tally_t exp;
      exp.status          = ST_OK;
      exp.rank_id         = '0;
      exp.rank_is_invalid = 1'b0;
      exp.rank_votes      = '0;
      case (op)
        OP_ADD: begin
          if (closed || used >= MAX_CHOICES) begin
            exp.status = ST_FULL;
          end else begin
            slot_ids[used] = id;
            slot_inv[used] = 1'b0;
            slot_cnt[used] = '0;
            used++;
          end
        end
        OP_CLOSE: begin
          if (closed || used >= TABLE_DEPTH) begin
            exp.status = ST_FULL;
          end else begin
            slot_ids[used] = '0;
            slot_inv[used] = 1'b1;
            slot_cnt[used] = '0;
            used++;
            closed = 1'b1;
          end
        end
        OP_VOTE: begin
          if (!closed) exp.status = ST_EARLY;
          else tally_vote(id);
        end
        default: begin
          if (rank >= used) begin
            exp.status = ST_RANGE;
          end else begin
            exp.rank_is_invalid = slot_inv[rank];
            exp.rank_id         = slot_inv[rank] ? '0 : slot_ids[rank];
            exp.rank_votes      = slot_cnt[rank];
          end
        end
      endcase
      exp.total_votes   = all_sum;
      exp.valid_votes   = valid_sum;
      exp.white_votes   = white_sum;
      exp.invalid_votes = invalid_sum;
      exp.entries_used  = 5'(used);
      expected_tallies.push_back(exp);
    endfunction

    task report(string msg);
      if (errors < PRINT_LIMIT) $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    function string field_msg(string field, logic [31:0] got, logic [31:0] exp);
      return $sformatf("result %0d %s: got %h, expected %h", results_seen, field,
                       got, exp);
    endfunction

    // Compare one returned result against the oldest prediction.
    task check_result(tally_t got);
      tally_t exp;
      if (expected_tallies.size() == 0) begin
        report($sformatf("result with no request pending, status %h", got.status));
        return;
      end
      exp = expected_tallies.pop_front();
      if (got.status !== exp.status)
        report(field_msg("status", got.status, exp.status));
      if (got.rank_id !== exp.rank_id)
        report(field_msg("rank_id", got.rank_id, exp.rank_id));
      if (got.rank_is_invalid !== exp.rank_is_invalid)
        report(field_msg("rank_is_invalid", got.rank_is_invalid, exp.rank_is_invalid));
      if (got.rank_votes !== exp.rank_votes)
        report(field_msg("rank_votes", got.rank_votes, exp.rank_votes));
      if (got.total_votes !== exp.total_votes)
        report(field_msg("total_votes", got.total_votes, exp.total_votes));
      if (got.valid_votes !== exp.valid_votes)
        report(field_msg("valid_votes", got.valid_votes, exp.valid_votes));
      if (got.white_votes !== exp.white_votes)
        report(field_msg("white_votes", got.white_votes, exp.white_votes));
      if (got.invalid_votes !== exp.invalid_votes)
        report(field_msg("invalid_votes", got.invalid_votes, exp.invalid_votes));
      if (got.entries_used !== exp.entries_used)
        report(field_msg("entries_used", got.entries_used, exp.entries_used));
      results_seen++;
    endtask
  endclass

endpackage

module tb_count_ranked_tally_table;
  import crtt_pkg::*;
  import tally_check_pkg::*;

  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int          RANDOM_REQUESTS = 800;
  localparam int          DRAIN_CYCLES    = 48;

  logic        clk                 = 1'b0;
  logic        rst_n               = 1'b0;
  logic        in_valid            = 1'b0;
  logic        in_ready;
  logic [1:0]  in_opcode           = OP_READ;
  logic [15:0] in_choice_id        = '0;
  logic [4:0]  in_rank             = '0;
  logic        out_valid;
  logic        out_ready           = 1'b0;
  logic [1:0]  out_status;
  logic [15:0] out_rank_id;
  logic        out_rank_is_invalid;
  logic [31:0] out_rank_votes;
  logic [31:0] out_total_votes;
  logic [31:0] out_valid_votes;
  logic [31:0] out_white_votes;
  logic [31:0] out_invalid_votes;
  logic [4:0]  out_entries_used;

  int          send_idle_pct  = 17;
  int          recv_stall_pct = 55;
  int unsigned cycle_count    = 0;
  tally_ledger ledger;
  bit [ID_W-1:0] choice_pool[$];

  count_ranked_tally_table DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Give up on a hung block.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_count_ranked_tally_table: errors");
      $finish;
    end
  end

  // The receiver stalls at random according to the current pattern.
  always @(posedge clk) begin
    out_ready <= rst_n && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Every request the block takes is entered in the ledger.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      ledger.note_request(opcode_t'(in_opcode), in_choice_id, in_rank);
  end

  // Every result the block hands over is checked.
  always @(posedge clk) begin : result_check
    tally_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status          = status_t'(out_status);
      got.rank_id         = out_rank_id;
      got.rank_is_invalid = out_rank_is_invalid;
      got.rank_votes      = out_rank_votes;
      got.total_votes     = out_total_votes;
      got.valid_votes     = out_valid_votes;
      got.white_votes     = out_white_votes;
      got.invalid_votes   = out_invalid_votes;
      got.entries_used    = out_entries_used;
      ledger.check_result(got);
    end
  end

  // Present one request, after an optional gap, and hold it until taken.
  task automatic send_request(opcode_t op, bit [ID_W-1:0] id, bit [4:0] rank);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_choice_id <= id;
    in_rank      <= rank;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random traffic after close: mostly votes and reads, some late adds
  // and closes. Only votes and reads count toward the number asked.
  task automatic run_random(int count);
    int            done;
    int            pick;
    int            idx;
    int            alt;
    bit [ID_W-1:0] id;
    bit [4:0]      rank;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      id   = ID_W'($urandom);
      if ($urandom_range(0, 9) == 0) rank = 5'($urandom_range(0, 31));
      else rank = 5'($urandom_range(0, TABLE_DEPTH - 1));
      if (pick < 50) begin
        // Favor the early choices so some of them pull well ahead.
        idx = $urandom_range(0, choice_pool.size() - 1);
        alt = $urandom_range(0, choice_pool.size() - 1);
        if (alt < idx) idx = alt;
        send_request(OP_VOTE, choice_pool[idx], rank);
        done++;
      end else if (pick < 62) begin
        send_request(OP_VOTE, id, rank);
        done++;
      end else if (pick < 90) begin
        send_request(OP_READ, id, rank);
        done++;
      end else if (pick < 95) begin
        send_request(OP_ADD, id, rank);
      end else begin
        send_request(OP_CLOSE, id, rank);
      end
    end
  endtask

  initial begin
    bit [ID_W-1:0] id;
    bit [ID_W-1:0] edge_ids[5];
    edge_ids = '{16'h0000, 16'hFFFF, 16'h5A5A, 16'hA5A5, 16'h0000};
    ledger = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: a read is out of range and a vote comes too early.
    send_request(OP_READ, 16'h0000, 5'd0);
    send_request(OP_VOTE, 16'h0000, 5'd0);

    // Fill every choice, with the white id, the top id and a duplicate.
    for (int i = 0; i < MAX_CHOICES; i++) begin
      if (i < 5) id = edge_ids[i];
      else if ($urandom_range(0, 1)) id = choice_pool[$urandom_range(0, i - 1)];
      else id = ID_W'($urandom);
      choice_pool.push_back(id);
      send_request(OP_ADD, id, 5'd0);
    end

    // Add to a full table, close twice, then add after close.
    send_request(OP_ADD, 16'h1234, 5'd0);
    send_request(OP_CLOSE, 16'h0000, 5'd0);
    send_request(OP_CLOSE, 16'h0000, 5'd0);
    send_request(OP_ADD, 16'h4321, 5'd0);

    // Votes that bubble the top id up and feed the invalid entry.
    send_request(OP_VOTE, 16'hFFFF, 5'd31);
    send_request(OP_VOTE, 16'hFFFF, 5'd0);
    send_request(OP_VOTE, 16'hC3C3, 5'd0);
    send_request(OP_READ, 16'h0000, 5'd16);
    send_request(OP_READ, 16'hFFFF, 5'd17);
    send_request(OP_READ, 16'h0000, 5'd31);

    run_random(RANDOM_REQUESTS / 3);
    send_idle_pct  = 55;
    recv_stall_pct = 17;
    run_random(RANDOM_REQUESTS / 3);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    run_random(RANDOM_REQUESTS - 2 * (RANDOM_REQUESTS / 3));
    in_valid <= 1'b0;

    // Drain, then allow any stray result time to show up.
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("tb_count_ranked_tally_table: clean");
    end else begin
      $display("tb_count_ranked_tally_table: errors");
    end
    $finish;
  end

endmodule
